// ===== rtl/qvr_pkg.sv =====
// Shared constants and types for the quaternion vector rotation block.
package qvr_pkg;

  localparam int QUAT_WIDTH         = 16;
  localparam int ROT_WIDTH          = 18;
  localparam int VEC_WIDTH_DEF      = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int NUM_STAGES         = 5;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // register word index (paddr[3:2])
  localparam logic [1:0] REG_QUAT_X = 2'd0;
  localparam logic [1:0] REG_QUAT_Y = 2'd1;
  localparam logic [1:0] REG_QUAT_Z = 2'd2;
  localparam logic [1:0] REG_QUAT_W = 2'd3;

  localparam logic signed [QUAT_WIDTH-1:0] QUAT_ZERO = '0;
  localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE  = QUAT_WIDTH'(16384);

  // per-stage load enables from the handshake control to the datapath
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } qvr_pipe_ctl_t;

endpackage

// ===== rtl/quaternion_vector_rotate.sv =====
// Top level: quaternion registers, pipeline handshake control and datapath.
//
// Rotates 3-D vectors by the quaternion (quat_x, quat_y, quat_z, quat_w), signed Q2.14.
// Input beats arrive on in_valid / in_vec_*; the block holds off new beats with in_stall.
// Result beats leave on out_valid / out_rot_*; the receiver holds them with out_stall.
// A beat is taken at a clock edge where valid is high and stall is low.
// Five register stages lie between input and output, the first loaded at the edge that
// takes the input beat: partial products, cross product, scaling products, rounding add,
// saturation; out_valid is the valid bit of the last stage.
// Throughput: one vector per cycle while out_stall is low; every stage holds one item at a time.
// When out_stall is high the last stage holds its beat; earlier stages keep filling empty
// slots, so in_stall rises only once every stage holds a beat.
// Quaternion registers sit on an APB port at byte addresses 0, 4, 8, 12 (x, y, z, w);
// write them only while no beat is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity quaternion.
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [VEC_WIDTH-1:0]            in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]            in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]            in_vec_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qvr_pkg::ROT_WIDTH-1:0]   out_rot_x,
  output logic signed [qvr_pkg::ROT_WIDTH-1:0]   out_rot_y,
  output logic signed [qvr_pkg::ROT_WIDTH-1:0]   out_rot_z,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [qvr_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [qvr_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import qvr_pkg::*;

  logic signed [QUAT_WIDTH-1:0] quat_x_r, quat_y_r, quat_z_r, quat_w_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;
  logic [NUM_STAGES-1:0]        vld_r;
  logic [NUM_STAGES-1:0]        vld_nxt;
  qvr_pipe_ctl_t                ctl;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_x_r <= QUAT_ZERO;
      quat_y_r <= QUAT_ZERO;
      quat_z_r <= QUAT_ZERO;
      quat_w_r <= QUAT_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_QUAT_X: quat_x_r <= pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_Y: quat_y_r <= pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_Z: quat_z_r <= pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_W: quat_w_r <= pwdata[QUAT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_QUAT_X: prdata = CFG_DATA_W'(unsigned'(quat_x_r));
      REG_QUAT_Y: prdata = CFG_DATA_W'(unsigned'(quat_y_r));
      REG_QUAT_Z: prdata = CFG_DATA_W'(unsigned'(quat_z_r));
      REG_QUAT_W: prdata = CFG_DATA_W'(unsigned'(quat_w_r));
      default:    prdata = '0;
    endcase
  end

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    ctl.load[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctl.load[k] = !vld_r[k] || ctl.load[k+1];
    end
    vld_nxt[0] = ctl.load[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = ctl.load[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ctl.load[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  qvr_datapath #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .ctl    (ctl),
    .quat_x (quat_x_r),
    .quat_y (quat_y_r),
    .quat_z (quat_z_r),
    .quat_w (quat_w_r),
    .vec_x  (in_vec_x),
    .vec_y  (in_vec_y),
    .vec_z  (in_vec_z),
    .rot_x  (out_rot_x),
    .rot_y  (out_rot_y),
    .rot_z  (out_rot_z)
  );

endmodule

// ===== rtl/qvr_datapath.sv =====
// Five-stage arithmetic pipeline: cross products, scaling, rounding, saturation.
module qvr_datapath #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  qvr_pkg::qvr_pipe_ctl_t                  ctl,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]   quat_x,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]   quat_y,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]   quat_z,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0]   quat_w,
  input  logic signed [VEC_WIDTH-1:0]             vec_x,
  input  logic signed [VEC_WIDTH-1:0]             vec_y,
  input  logic signed [VEC_WIDTH-1:0]             vec_z,
  output logic signed [qvr_pkg::ROT_WIDTH-1:0]    rot_x,
  output logic signed [qvr_pkg::ROT_WIDTH-1:0]    rot_y,
  output logic signed [qvr_pkg::ROT_WIDTH-1:0]    rot_z
);
  import qvr_pkg::*;

  localparam int P_W   = QUAT_WIDTH + VEC_WIDTH;
  localparam int A_W   = P_W + 1;
  localparam int T_W   = QUAT_WIDTH + A_W;
  localparam int SH    = 2 * QUAT_FRAC_BITS;
  localparam int S_MIN = T_W + 4;
  localparam int S_W   = (S_MIN > SH + 1) ? S_MIN : SH + 1;
  localparam int D_W   = S_W - SH;
  localparam int R_W   = ((VEC_WIDTH > D_W) ? VEC_WIDTH : D_W) + 1;
  localparam int C_W   = (R_W > ROT_WIDTH + 1) ? R_W : ROT_WIDTH + 1;

  localparam logic signed [S_W-1:0] RND    = S_W'(1) <<< (SH - 1);
  localparam logic signed [C_W-1:0] SAT_HI = C_W'((1 <<< (ROT_WIDTH - 1)) - 1);
  localparam logic signed [C_W-1:0] SAT_LO = ~SAT_HI;

  // stage 1: six partial products of u x v
  logic signed [P_W-1:0] p_yz_nxt, p_zy_nxt, p_zx_nxt, p_xz_nxt, p_xy_nxt, p_yx_nxt;
  logic signed [P_W-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [VEC_WIDTH-1:0] v1_r [3];

  // stage 2: a = u x v
  logic signed [A_W-1:0] ax_nxt, ay_nxt, az_nxt;
  logic signed [A_W-1:0] ax_r, ay_r, az_r;
  logic signed [VEC_WIDTH-1:0] v2_r [3];

  // stage 3: terms of w*a + u x a
  logic signed [T_W-1:0] t_nxt [3][3];
  logic signed [T_W-1:0] t_r   [3][3];
  logic signed [VEC_WIDTH-1:0] v3_r [3];

  // stage 4: 2b with rounding offset
  logic signed [S_W-1:0] s_nxt [3];
  logic signed [S_W-1:0] s_r   [3];
  logic signed [VEC_WIDTH-1:0] v4_r [3];

  // stage 5: v + 2b, saturated
  logic signed [D_W-1:0]       d_w   [3];
  logic signed [C_W-1:0]       sum_w [3];
  logic signed [ROT_WIDTH-1:0] rot_nxt [3];
  logic signed [ROT_WIDTH-1:0] rot_r   [3];

  assign p_yz_nxt = quat_y * vec_z;
  assign p_zy_nxt = quat_z * vec_y;
  assign p_zx_nxt = quat_z * vec_x;
  assign p_xz_nxt = quat_x * vec_z;
  assign p_xy_nxt = quat_x * vec_y;
  assign p_yx_nxt = quat_y * vec_x;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      p_yz_r <= p_yz_nxt;
      p_zy_r <= p_zy_nxt;
      p_zx_r <= p_zx_nxt;
      p_xz_r <= p_xz_nxt;
      p_xy_r <= p_xy_nxt;
      p_yx_r <= p_yx_nxt;
      v1_r[0] <= vec_x;
      v1_r[1] <= vec_y;
      v1_r[2] <= vec_z;
    end
  end

  assign ax_nxt = A_W'(p_yz_r) - A_W'(p_zy_r);
  assign ay_nxt = A_W'(p_zx_r) - A_W'(p_xz_r);
  assign az_nxt = A_W'(p_xy_r) - A_W'(p_yx_r);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
      v2_r <= v1_r;
    end
  end

  // per component: w*a_i, plus term, minus term
  assign t_nxt[0][0] = quat_w * ax_r;
  assign t_nxt[0][1] = quat_y * az_r;
  assign t_nxt[0][2] = quat_z * ay_r;
  assign t_nxt[1][0] = quat_w * ay_r;
  assign t_nxt[1][1] = quat_z * ax_r;
  assign t_nxt[1][2] = quat_x * az_r;
  assign t_nxt[2][0] = quat_w * az_r;
  assign t_nxt[2][1] = quat_x * ay_r;
  assign t_nxt[2][2] = quat_y * ax_r;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      t_r  <= t_nxt;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_nxt[i] = ((S_W'(t_r[i][0]) + S_W'(t_r[i][1]) - S_W'(t_r[i][2])) <<< 1) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s_r  <= s_nxt;
      v4_r <= v3_r;
    end
  end

  // drop the fraction bits (floor), add v, clamp to the output range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i]   = $signed(s_r[i][S_W-1:SH]);
      sum_w[i] = C_W'(v4_r[i]) + C_W'(d_w[i]);
      if (sum_w[i] > SAT_HI) begin
        rot_nxt[i] = SAT_HI[ROT_WIDTH-1:0];
      end else if (sum_w[i] < SAT_LO) begin
        rot_nxt[i] = SAT_LO[ROT_WIDTH-1:0];
      end else begin
        rot_nxt[i] = sum_w[i][ROT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot_x = rot_r[0];
  assign rot_y = rot_r[1];
  assign rot_z = rot_r[2];

endmodule

// ===== rtl/qvr_assert.sv =====
// Port-level assertions for the rotation block, bound to the top level.
module qvr_assert (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [qvr_pkg::ROT_WIDTH-1:0]  out_rot_x,
  input logic signed [qvr_pkg::ROT_WIDTH-1:0]  out_rot_y,
  input logic signed [qvr_pkg::ROT_WIDTH-1:0]  out_rot_z
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // with the output draining, the pipeline always has room
  a_no_stall_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("in_stall high while output not stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rot_x) && $stable(out_rot_y) && $stable(out_rot_z))
    else $error("stalled result beat changed");

endmodule

bind quaternion_vector_rotate qvr_assert u_qvr_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rot_x (out_rot_x),
  .out_rot_y (out_rot_y),
  .out_rot_z (out_rot_z)
);
